/* rtl/papc_pkg.sv */
`timescale 1ns / 1ps

package papc_pkg;

  localparam int POS_W   = 18;
  localparam int TGT_W   = 15;
  localparam int LIM_W   = 7;
  localparam int ERR_W   = 20;
  localparam int ELAP_W  = 11;
  localparam int DRIVE_W = 8;
  localparam int SEL_W   = 3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_BAND   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd3;

  localparam logic [15:0] PROP_GAIN_RST     = 16'd2032;
  localparam logic [15:0] DERIV_GAIN_RST    = 16'd3604;
  localparam logic [11:0] SETTLE_BAND_RST   = 12'd150;
  localparam logic [9:0]  TIMEOUT_TICKS_RST = 10'd50;

  localparam logic [LIM_W-1:0]          LIMIT_DEFAULT = 7'd80;
  localparam logic signed [DRIVE_W-1:0] DRIVE_HOME    = -8'sd50;
  localparam logic [SEL_W-1:0]          NUM_PRESETS   = 3'd5;
  localparam logic [SEL_W-1:0]          PRESET_HOLD   = 3'd1;

  typedef enum logic [0:0] {
    OP_TICK = 1'b0,
    OP_MOVE = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    BRAKE_KEEP  = 2'd0,
    BRAKE_HOLD  = 2'd1,
    BRAKE_COAST = 2'd2
  } brake_mode_e;

  typedef struct packed {
    logic [15:0] prop_gain;
    logic [15:0] deriv_gain;
    logic [11:0] settle_band;
    logic [9:0]  timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [TGT_W-1:0]        target_pos;
    logic [LIM_W-1:0]        speed_limit;
    logic signed [ERR_W-1:0] last_error;
    logic                    move_done;
    logic [ELAP_W-1:0]       elapsed_ticks;
  } state_t;

  typedef struct packed {
    logic [SEL_W-1:0]        preset_select;
    logic                    opcode;
    logic signed [POS_W-1:0] arm_position;
  } item_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      drive_valid;
    logic                      brake_now;
    brake_mode_e               brake_mode;
    logic                      homing;
    logic                      done_res;
  } result_t;

  function automatic logic [TGT_W-1:0] preset_target(logic [SEL_W-1:0] sel);
    logic [TGT_W-1:0] t;
    case (sel)
      3'd0:    t = 15'd0;
      3'd1:    t = 15'd4000;
      3'd2:    t = 15'd7000;
      3'd3:    t = 15'd14000;
      3'd4:    t = 15'd18000;
      default: t = 15'd0;
    endcase
    return t;
  endfunction

  function automatic logic [LIM_W-1:0] preset_limit(logic [SEL_W-1:0] sel);
    logic [LIM_W-1:0] l;
    case (sel)
      3'd0:    l = 7'd80;
      3'd1:    l = 7'd50;
      3'd2:    l = 7'd50;
      3'd3:    l = 7'd80;
      3'd4:    l = 7'd127;
      default: l = LIMIT_DEFAULT;
    endcase
    return l;
  endfunction

endpackage

/* rtl/papc_cfg_regs.sv */
`timescale 1ns / 1ps

module papc_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [papc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [papc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output papc_pkg::cfg_t                      cfg_o
);

  papc_pkg::cfg_t cfg_q;
  papc_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        papc_pkg::REG_PROP_GAIN:     cfg_d.prop_gain     = cfg_wdata_i;
        papc_pkg::REG_DERIV_GAIN:    cfg_d.deriv_gain    = cfg_wdata_i;
        papc_pkg::REG_SETTLE_BAND:   cfg_d.settle_band   = cfg_wdata_i[11:0];
        papc_pkg::REG_TIMEOUT_TICKS: cfg_d.timeout_ticks = cfg_wdata_i[9:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain     <= papc_pkg::PROP_GAIN_RST;
      cfg_q.deriv_gain    <= papc_pkg::DERIV_GAIN_RST;
      cfg_q.settle_band   <= papc_pkg::SETTLE_BAND_RST;
      cfg_q.timeout_ticks <= papc_pkg::TIMEOUT_TICKS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/papc_pd_law.sv */
`timescale 1ns / 1ps

module papc_pd_law #(
  parameter int GAIN_FRAC_BITS = 16
) (
  input  papc_pkg::cfg_t    cfg_i,
  input  papc_pkg::state_t  state_i,
  input  papc_pkg::item_t   item_i,
  output papc_pkg::state_t  state_o,
  output papc_pkg::result_t result_o
);

  localparam int ERR_W  = papc_pkg::ERR_W;
  localparam int DER_W  = ERR_W + 1;
  localparam int PROD_W = 17 + DER_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int LIM_W  = papc_pkg::LIM_W;

  logic signed [ERR_W-1:0]  err;
  logic signed [DER_W-1:0]  der;
  logic signed [PROD_W-1:0] prod_p;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  lim_sc;
  logic [ACC_W-1:0]         acc_mag;
  logic [ACC_W-1:0]         acc_shift;
  logic signed [papc_pkg::DRIVE_W-1:0] power;
  logic [ERR_W-1:0]         err_mag;
  logic [papc_pkg::ELAP_W-1:0] elap_next;
  logic                     finish;
  logic                     sel_ok;

  assign err = ERR_W'(signed'({1'b0, state_i.target_pos}))
             - ERR_W'(item_i.arm_position);
  assign der = DER_W'(err) - DER_W'(state_i.last_error);

  assign prod_p = PROD_W'(signed'({1'b0, cfg_i.prop_gain})) * PROD_W'(err);
  assign prod_d = PROD_W'(signed'({1'b0, cfg_i.deriv_gain})) * PROD_W'(der);
  assign acc    = ACC_W'(prod_p) + ACC_W'(prod_d);

  assign lim_sc    = signed'(ACC_W'(state_i.speed_limit)) <<< GAIN_FRAC_BITS;
  assign acc_mag   = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  assign acc_shift = acc_mag >> GAIN_FRAC_BITS;

  always_comb begin
    priority if (acc > lim_sc) begin
      power = signed'({1'b0, state_i.speed_limit});
    end else if (acc < -lim_sc) begin
      power = -signed'({1'b0, state_i.speed_limit});
    end else if (!acc[ACC_W-1]) begin
      power = signed'({1'b0, acc_shift[LIM_W-1:0]});
    end else begin
      power = -signed'({1'b0, acc_shift[LIM_W-1:0]});
    end
  end

  assign err_mag   = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
  assign elap_next = (&state_i.elapsed_ticks) ? state_i.elapsed_ticks
                                              : state_i.elapsed_ticks + 1'b1;
  assign finish = (err_mag < ERR_W'(cfg_i.settle_band))
               || (elap_next > papc_pkg::ELAP_W'(cfg_i.timeout_ticks));
  assign sel_ok = item_i.preset_select < papc_pkg::NUM_PRESETS;

  always_comb begin
    state_o              = state_i;
    result_o.drive       = '0;
    result_o.drive_valid = 1'b0;
    result_o.brake_now   = 1'b0;
    result_o.brake_mode  = papc_pkg::BRAKE_KEEP;
    result_o.homing      = 1'b0;
    result_o.done_res    = 1'b0;
    if (item_i.opcode == papc_pkg::OP_MOVE) begin
      state_o.move_done     = 1'b0;
      state_o.elapsed_ticks = '0;
      state_o.speed_limit   = papc_pkg::preset_limit(item_i.preset_select);
      if (sel_ok) begin
        state_o.target_pos = papc_pkg::preset_target(item_i.preset_select);
      end
      if (item_i.preset_select == papc_pkg::PRESET_HOLD) begin
        result_o.brake_mode = papc_pkg::BRAKE_HOLD;
      end
    end else if (state_i.move_done) begin
      state_o.elapsed_ticks = '0;
      result_o.done_res     = 1'b1;
    end else begin
      state_o.elapsed_ticks = elap_next;
      if (finish) begin
        state_o.move_done  = 1'b1;
        state_o.last_error = '0;
        result_o.done_res  = 1'b1;
        if (state_i.target_pos == '0) begin
          result_o.drive       = papc_pkg::DRIVE_HOME;
          result_o.drive_valid = 1'b1;
          result_o.brake_now   = 1'b1;
          result_o.brake_mode  = papc_pkg::BRAKE_COAST;
          result_o.homing      = 1'b1;
        end else begin
          result_o.brake_now  = 1'b1;
          result_o.brake_mode = papc_pkg::BRAKE_HOLD;
        end
      end else begin
        state_o.last_error   = err;
        result_o.drive       = power;
        result_o.drive_valid = 1'b1;
      end
    end
  end

endmodule

/* rtl/preset_arm_pd_position_controller.sv */
// Channel   Direction  Handshake               Payload
// input     in         in_valid_i / in_stall_o  opcode_i, preset_select_i, arm_position_i
// result    out        out_valid_o / out_stall_i drive_o, drive_valid_o, brake_now_o,
//                                               brake_mode_o, homing_o, done_res_o
// config    in         cfg_we_i                 cfg_index_i, cfg_wdata_i
//
// One transaction per cycle while the result channel is not stalled. An input passes the
// input register, one pass of the PD law (two parallel multiplies, one add, clamp) and
// the result register.
// Reset clears both valids and the move state (marked done); loads the register defaults.
// A stalled result holds; the input register still takes one more transaction.
`timescale 1ns / 1ps

module preset_arm_pd_position_controller #(
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic                                    opcode_i,
  input  logic [papc_pkg::SEL_W-1:0]              preset_select_i,
  input  logic signed [papc_pkg::POS_W-1:0]       arm_position_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [papc_pkg::DRIVE_W-1:0]     drive_o,
  output logic                                    drive_valid_o,
  output logic                                    brake_now_o,
  output logic [1:0]                              brake_mode_o,
  output logic                                    homing_o,
  output logic                                    done_res_o,
  input  logic                                    cfg_we_i,
  input  logic [papc_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [papc_pkg::CFG_DATA_W-1:0]         cfg_wdata_i
);

  papc_pkg::cfg_t    cfg;
  papc_pkg::item_t   item_q;
  papc_pkg::state_t  state_q;
  papc_pkg::state_t  state_d;
  papc_pkg::result_t res_q;
  papc_pkg::result_t res_d;
  logic              s1_valid_q;
  logic              out_valid_q;
  logic              adv;
  logic              in_take;
  logic              fire;

  papc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  papc_pd_law #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_law (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  assign adv        = !out_valid_q || !out_stall_i;
  assign fire       = adv && s1_valid_q;
  assign in_stall_o = s1_valid_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q            <= 1'b0;
      out_valid_q           <= 1'b0;
      state_q.target_pos    <= '0;
      state_q.speed_limit   <= papc_pkg::LIMIT_DEFAULT;
      state_q.last_error    <= '0;
      state_q.move_done     <= 1'b1;
      state_q.elapsed_ticks <= '0;
    end else begin
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= s1_valid_q;
      end
      if (fire) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.opcode        <= opcode_i;
      item_q.preset_select <= preset_select_i;
      item_q.arm_position  <= arm_position_i;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign drive_o       = res_q.drive;
  assign drive_valid_o = res_q.drive_valid;
  assign brake_now_o   = res_q.brake_now;
  assign brake_mode_o  = 2'(res_q.brake_mode);
  assign homing_o      = res_q.homing;
  assign done_res_o    = res_q.done_res;

endmodule

/* rtl/papc_checker.sv */
`timescale 1ns / 1ps

module papc_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [papc_pkg::DRIVE_W-1:0] drive_o,
  input logic                                drive_valid_o,
  input logic                                brake_now_o,
  input logic [1:0]                          brake_mode_o,
  input logic                                homing_o,
  input logic                                done_res_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(drive_o)
      && $stable(done_res_o) && $stable(brake_mode_o))
    else $error("stalled result changed");

  a_idle_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !drive_valid_o |-> drive_o == '0)
    else $error("drive nonzero while not driving");

  a_homing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && homing_o |-> drive_o == papc_pkg::DRIVE_HOME && done_res_o
      && brake_mode_o == 2'(papc_pkg::BRAKE_COAST))
    else $error("homing result malformed");

  a_brake_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && brake_now_o |-> done_res_o)
    else $error("brake without finished move");

endmodule

bind preset_arm_pd_position_controller papc_checker u_papc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .drive_o       (drive_o),
  .drive_valid_o (drive_valid_o),
  .brake_now_o   (brake_now_o),
  .brake_mode_o  (brake_mode_o),
  .homing_o      (homing_o),
  .done_res_o    (done_res_o)
);

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import papc_pkg::*;

  localparam int FRAC        = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 145;

  typedef struct packed {
    item_t   it;
    bit      fixed;
    result_t want;
  } dir_row_t;

  logic                      clk_i;
  logic                      rst_ni          = 1'b0;
  logic                      in_valid_i      = 1'b0;
  logic                      in_stall_o;
  logic                      opcode_i        = OP_TICK;
  logic [SEL_W-1:0]          preset_select_i = '0;
  logic signed [POS_W-1:0]   arm_position_i  = '0;
  logic                      out_valid_o;
  logic                      out_stall_i     = 1'b0;
  logic signed [DRIVE_W-1:0] drive_o;
  logic                      drive_valid_o;
  logic                      brake_now_o;
  logic [1:0]                brake_mode_o;
  logic                      homing_o;
  logic                      done_res_o;
  logic                      cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index_i     = '0;
  logic [CFG_DATA_W-1:0]     cfg_wdata_i     = '0;

  // controller model state
  int     arm_target   = 0;
  int     arm_limit    = 80;
  int     arm_elapsed  = 0;
  longint arm_last_err = 0;
  bit     arm_done     = 1'b1;
  longint cfg_kp       = 2032;
  longint cfg_kd       = 3604;
  longint cfg_band     = 150;
  longint cfg_tmo      = 50;

  result_t     pending_results [$];
  result_t     want_res;
  dir_row_t    dir_rows [$];
  int          fail_count   = 0;
  int          result_count = 0;
  int          cycle_count  = 0;
  bit          calm         = 1'b0;
  int          stall_left   = 0;
  int unsigned stall_roll;

  preset_arm_pd_position_controller #(
    .GAIN_FRAC_BITS(FRAC)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .preset_select_i(preset_select_i),
    .arm_position_i (arm_position_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .drive_o        (drive_o),
    .drive_valid_o  (drive_valid_o),
    .brake_now_o    (brake_now_o),
    .brake_mode_o   (brake_mode_o),
    .homing_o       (homing_o),
    .done_res_o     (done_res_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic result_t step_arm(item_t it);
    result_t r;
    longint  pos;
    longint  err;
    longint  der;
    longint  acc;
    longint  cap;
    longint  power;
    longint  mag;
    r = '0;
    if (it.opcode == OP_MOVE) begin
      arm_done    = 1'b0;
      arm_elapsed = 0;
      arm_limit   = 80;
      if (it.preset_select < NUM_PRESETS) begin
        case (it.preset_select)
          3'd0: begin arm_target = 0;     arm_limit = 80;  end
          3'd1: begin arm_target = 4000;  arm_limit = 50;  end
          3'd2: begin arm_target = 7000;  arm_limit = 50;  end
          3'd3: begin arm_target = 14000; arm_limit = 80;  end
          default: begin arm_target = 18000; arm_limit = 127; end
        endcase
      end
      if (it.preset_select == PRESET_HOLD) r.brake_mode = BRAKE_HOLD;
      return r;
    end
    if (arm_done) begin
      arm_elapsed = 0;
      r.done_res  = 1'b1;
      return r;
    end
    if (arm_elapsed < 2047) arm_elapsed++;
    pos = it.arm_position;
    err = longint'(arm_target) - pos;
    der = err - arm_last_err;
    acc = cfg_kp * err + cfg_kd * der;
    cap = longint'(arm_limit) <<< FRAC;
    if (acc > cap) power = arm_limit;
    else if (acc < -cap) power = -arm_limit;
    else power = acc / (longint'(1) <<< FRAC);
    mag = (err < 0) ? -err : err;
    if (mag < cfg_band || longint'(arm_elapsed) > cfg_tmo) begin
      arm_done     = 1'b1;
      arm_last_err = 0;
      r.brake_now  = 1'b1;
      r.done_res   = 1'b1;
      if (arm_target == 0) begin
        r.drive       = DRIVE_HOME;
        r.drive_valid = 1'b1;
        r.brake_mode  = BRAKE_COAST;
        r.homing      = 1'b1;
      end else begin
        r.brake_mode = BRAKE_HOLD;
      end
      return r;
    end
    arm_last_err  = err;
    r.drive       = power[7:0];
    r.drive_valid = 1'b1;
    return r;
  endfunction

  function automatic item_t mk_item(logic op, logic [SEL_W-1:0] sel, int pos);
    item_t it;
    it.opcode        = op;
    it.preset_select = sel;
    it.arm_position  = pos[POS_W-1:0];
    return it;
  endfunction

  function automatic result_t mk_res(int drv, bit dv, bit bn, brake_mode_e bm, bit hm,
                                     bit dn);
    result_t r;
    r.drive       = drv[7:0];
    r.drive_valid = dv;
    r.brake_now   = bn;
    r.brake_mode  = bm;
    r.homing      = hm;
    r.done_res    = dn;
    return r;
  endfunction

  function automatic int pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_position();
    int unsigned roll;
    int          span;
    int          off;
    roll = $urandom_range(0, 9);
    if (roll == 0) return int'($urandom_range(0, 262143)) - 131072;
    if (roll == 1) begin
      off = int'(cfg_band) + int'($urandom_range(0, 2)) - 1;
      return ($urandom_range(0, 1) == 1) ? arm_target + off : arm_target - off;
    end
    span = (roll < 4) ? 60000 : (roll < 7) ? 3000 : 300;
    return arm_target + int'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic add_row(logic op, logic [SEL_W-1:0] sel, int pos, bit fixed,
                         result_t want);
    dir_row_t row;
    row.it    = mk_item(op, sel, pos);
    row.fixed = fixed;
    row.want  = want;
    dir_rows.push_back(row);
  endtask

  task automatic send_item(item_t it, bit fixed, result_t want);
    int      gap;
    result_t predicted;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    opcode_i        <= it.opcode;
    preset_select_i <= it.preset_select;
    arm_position_i  <= it.arm_position;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    predicted = step_arm(it);
    pending_results.push_back(fixed ? want : predicted);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val[CFG_DATA_W-1:0];
    @(posedge clk_i);
  endtask

  task automatic set_config(int unsigned p, int unsigned d, int unsigned b, int unsigned t);
    put_reg(REG_PROP_GAIN, p);
    put_reg(REG_DERIV_GAIN, d);
    put_reg(REG_SETTLE_BAND, b);
    put_reg(REG_TIMEOUT_TICKS, t);
    cfg_we_i <= 1'b0;
    cfg_kp   = p & 16'hFFFF;
    cfg_kd   = d & 16'hFFFF;
    cfg_band = b & 12'hFFF;
    cfg_tmo  = t & 10'h3FF;
  endtask

  task automatic run_random(int budget);
    int          sent;
    int          ticks;
    logic [2:0]  sel;
    logic        op;
    sent = 0;
    while (sent < budget) begin
      calm = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 9) == 0) begin
        op  = ($urandom_range(0, 1) == 0) ? OP_TICK : OP_MOVE;
        sel = 3'($urandom_range(0, 7));
        send_item(mk_item(op, sel, int'($urandom_range(0, 262143)) - 131072), 1'b0, '0);
        sent++;
      end else begin
        sel = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7))
                                          : 3'($urandom_range(0, 4));
        send_item(mk_item(OP_MOVE, sel, int'($urandom_range(0, 262143)) - 131072),
                  1'b0, '0);
        sent++;
        ticks = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 20);
        repeat (ticks) begin
          send_item(mk_item(OP_TICK, 3'($urandom_range(0, 7)), pick_position()), 1'b0, '0);
          sent++;
        end
      end
    end
    calm = 1'b0;
  endtask

  task automatic flag_mismatch(string field, longint got, longint want_v);
    $display("mismatch on %s at result %0d: got %0d, expected %0d",
             field, result_count, got, want_v);
    fail_count++;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni || calm) begin
      out_stall_i <= 1'b0;
      stall_left  = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 65) begin
        out_stall_i <= 1'b0;
      end else if (stall_roll < 95) begin
        out_stall_i <= 1'b1;
        stall_left  = $urandom_range(0, 2);
      end else begin
        out_stall_i <= 1'b1;
        stall_left  = $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected transaction", 0, 0);
      end else begin
        want_res = pending_results.pop_front();
        if (drive_o !== want_res.drive) flag_mismatch("drive", drive_o, want_res.drive);
        if (drive_valid_o !== want_res.drive_valid)
          flag_mismatch("drive_valid", drive_valid_o, want_res.drive_valid);
        if (brake_now_o !== want_res.brake_now)
          flag_mismatch("brake_now", brake_now_o, want_res.brake_now);
        if (brake_mode_o !== want_res.brake_mode)
          flag_mismatch("brake_mode", brake_mode_o, want_res.brake_mode);
        if (homing_o !== want_res.homing)
          flag_mismatch("homing", homing_o, want_res.homing);
        if (done_res_o !== want_res.done_res)
          flag_mismatch("done_res", done_res_o, want_res.done_res);
      end
      result_count++;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("preset_arm_pd_position_controller regression: fail");
    $finish;
  end

  initial begin
    add_row(OP_TICK, 3'd0, 0,       1'b1, mk_res(0, 0, 0, BRAKE_KEEP, 0, 1));
    add_row(OP_MOVE, 3'd1, 0,       1'b1, mk_res(0, 0, 0, BRAKE_HOLD, 0, 0));
    add_row(OP_TICK, 3'd0, 4000,    1'b1, mk_res(0, 0, 1, BRAKE_HOLD, 0, 1));
    add_row(OP_MOVE, 3'd4, -1,      1'b1, mk_res(0, 0, 0, BRAKE_KEEP, 0, 0));
    add_row(OP_TICK, 3'd7, -131072, 1'b0, '0);
    add_row(OP_TICK, 3'd0, 131071,  1'b0, '0);
    add_row(OP_TICK, 3'd0, 18000,   1'b1, mk_res(0, 0, 1, BRAKE_HOLD, 0, 1));
    add_row(OP_TICK, 3'd0, 18000,   1'b1, mk_res(0, 0, 0, BRAKE_KEEP, 0, 1));
    add_row(OP_MOVE, 3'd0, 131071,  1'b1, mk_res(0, 0, 0, BRAKE_KEEP, 0, 0));
    add_row(OP_TICK, 3'd0, 10,      1'b1, mk_res(-50, 1, 1, BRAKE_COAST, 1, 1));
    add_row(OP_MOVE, 3'd7, -131072, 1'b1, mk_res(0, 0, 0, BRAKE_KEEP, 0, 0));
    add_row(OP_TICK, 3'd0, 5000,    1'b0, '0);
    add_row(OP_TICK, 3'd0, -149,    1'b1, mk_res(-50, 1, 1, BRAKE_COAST, 1, 1));
    add_row(OP_MOVE, 3'd5, 0,       1'b1, mk_res(0, 0, 0, BRAKE_KEEP, 0, 0));
    add_row(OP_TICK, 3'd0, 3000,    1'b0, '0);
    add_row(OP_MOVE, 3'd2, 0,       1'b1, mk_res(0, 0, 0, BRAKE_KEEP, 0, 0));
    add_row(OP_TICK, 3'd0, 0,       1'b0, '0);
    add_row(OP_TICK, 3'd0, 6000,    1'b0, '0);
    add_row(OP_TICK, 3'd0, 6850,    1'b0, '0);
    add_row(OP_TICK, 3'd0, 6851,    1'b1, mk_res(0, 0, 1, BRAKE_HOLD, 0, 1));
    add_row(OP_MOVE, 3'd3, 0,       1'b1, mk_res(0, 0, 0, BRAKE_KEEP, 0, 0));
    add_row(OP_TICK, 3'd0, 14149,   1'b1, mk_res(0, 0, 1, BRAKE_HOLD, 0, 1));
    add_row(OP_MOVE, 3'd6, 0,       1'b1, mk_res(0, 0, 0, BRAKE_KEEP, 0, 0));
    add_row(OP_TICK, 3'd0, 14002,   1'b1, mk_res(0, 0, 1, BRAKE_HOLD, 0, 1));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].fixed, dir_rows[i].want);

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: set_config(0, 0, 0, 0);
        1: set_config(65535, 65535, 4095, 1023);
        2: set_config($urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, 65535));
        3: set_config(PROP_GAIN_RST, DERIV_GAIN_RST, $urandom_range(0, 400),
                      $urandom_range(1, 20));
        4: set_config($urandom_range(0, 8000), $urandom_range(0, 16000),
                      $urandom_range(50, 300), $urandom_range(5, 60));
        5: set_config($urandom_range(0, 65535), 0, 0, 1023);
        default: set_config(PROP_GAIN_RST, DERIV_GAIN_RST, SETTLE_BAND_RST,
                            TIMEOUT_TICKS_RST);
      endcase
      run_random(PHASE_ITEMS);
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("preset_arm_pd_position_controller regression: pass");
    end else begin
      $display("preset_arm_pd_position_controller regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/papc_pkg.sv
rtl/papc_cfg_regs.sv
rtl/papc_pd_law.sv
rtl/preset_arm_pd_position_controller.sv
rtl/papc_checker.sv
tb/tb.sv
